[rtl/core/fafr_pkg.sv]
package fafr_pkg;

	// Upper limit applied to max_ports
	localparam logic [4:0] FAFR_PORTS = 5'd16;

	// Reset value of max_ports
	localparam logic [4:0] FAFR_MAXP_RST = 5'd16;

	// Flow key, stored and compared as one word
	typedef struct packed {
		logic [15:0] dst_port;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [31:0] src_addr;
	} fafr_key_t;

	// Lookup probe walking down the row of slots
	typedef struct packed {
		logic       vld;
		fafr_key_t  key;
		logic       hit;
		logic [3:0] dest;
	} fafr_probe_t;

	// Insert command broadcast to all slots
	typedef struct packed {
		logic       en;
		fafr_key_t  key;
		logic [3:0] dest;
	} fafr_ins_t;

endpackage

[rtl/core/fafr_cell.sv]
module fafr_cell
	import fafr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  fafr_probe_t probe_in,
	output fafr_probe_t probe_out,
	input  logic        prev_filled,
	output logic        filled,
	input  fafr_ins_t   ins
);

	logic        filled_q;
	fafr_key_t   key_q;
	logic [3:0]  dest_q;
	logic        probe_vld_s1;
	fafr_key_t   probe_key_s1;
	logic        probe_hit_s1;
	logic [3:0]  probe_dest_s1;
	logic        match;

	// This slot is the first free one when its left neighbour is filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
		end else if (ins.en && prev_filled && !filled_q) begin
			filled_q <= 1'b1;
		end
	end

	// Stored flow, payload only
	always_ff @(posedge clk) begin
		if (ins.en && prev_filled && !filled_q) begin
			key_q  <= ins.key;
			dest_q <= ins.dest;
		end
	end

	assign match = filled_q && (probe_in.key == key_q);

	// Probe stage towards the next slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_vld_s1 <= 1'b0;
		end else if (adv) begin
			probe_vld_s1 <= probe_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			probe_key_s1  <= probe_in.key;
			probe_hit_s1  <= probe_in.hit | match;
			probe_dest_s1 <= match ? dest_q : probe_in.dest;
		end
	end

	assign probe_out.vld  = probe_vld_s1;
	assign probe_out.key  = probe_key_s1;
	assign probe_out.hit  = probe_hit_s1;
	assign probe_out.dest = probe_dest_s1;
	assign filled         = filled_q;

endmodule

[rtl/core/fafr_rr.sv]
module fafr_rr
	import fafr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_data,
	input  logic       step,
	output logic [3:0] port_nxt
);

	logic [4:0] max_ports_q;
	logic [3:0] pos_q;
	logic [4:0] eff;
	logic [4:0] inc;

	// Clamp max_ports to 1..FAFR_PORTS
	always_comb begin
		if (max_ports_q == 5'd0) begin
			eff = 5'd1;
		end else if (max_ports_q > FAFR_PORTS) begin
			eff = FAFR_PORTS;
		end else begin
			eff = max_ports_q;
		end
	end

	// Position stays below eff, so the modulo is a single wrap
	assign inc      = {1'b0, pos_q} + 5'd1;
	assign port_nxt = (inc >= eff) ? 4'd0 : inc[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ports_q <= FAFR_MAXP_RST;
			pos_q       <= 4'd0;
		end else if (cfg_we) begin
			max_ports_q <= cfg_data;
			pos_q       <= 4'd0;
		end else if (step) begin
			pos_q <= port_nxt;
		end
	end

endmodule

[rtl/core/flow_affinity_round_robin.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  src_addr, src_port, dst_addr, dst_port
// m_*       out  m_tvalid/m_tready  out_port, is_new_flow, table_full, flow_total
// cfg_*     in   cfg_we             max_ports
//
// One item at a time: its probe walks the row of FLOWS slots, one slot a cycle while
// the row advances; the input reopens once the result is registered, so a new item
// is not taken before the last is through. A new flow is inserted as the result is
// registered. Reset clears slot fill flags, flow count and round-robin state.
// A result waiting on m_tready freezes the whole row and holds s_tready low.
module flow_affinity_round_robin
	import fafr_pkg::*;
#(
	parameter int FLOWS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] src_addr, [47:32] src_port, [79:48] dst_addr, [95:80] dst_port
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] out_port, [4] is_new_flow, [5] table_full, [14:6] flow_total
	output logic [15:0] m_tdata
);

	localparam int CW = $clog2(FLOWS + 1);

	fafr_probe_t         probe [FLOWS+1];
	logic [FLOWS:0]      fill;
	fafr_ins_t           ins;
	logic                adv;
	logic                busy_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic                full;
	logic                tail_done;
	logic                rr_step;
	logic [3:0]          rr_port;
	logic [3:0]          res_port;
	logic [31:0]         total_ext;
	logic                out_vld_q;
	logic [15:0]         out_data_q;

	// Probe injection at the head of the row
	assign probe[0].vld  = s_tvalid & s_tready;
	assign probe[0].key  = {s_tdata[95:80], s_tdata[79:48], s_tdata[47:32], s_tdata[31:0]};
	assign probe[0].hit  = 1'b0;
	assign probe[0].dest = 4'd0;
	assign fill[0]       = 1'b1;

	// Row of flow slots
	genvar g;
	for (g = 0; g < FLOWS; g++) begin : g_slot
		fafr_cell u_slot (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.probe_in    (probe[g]),
			.probe_out   (probe[g+1]),
			.prev_filled (fill[g]),
			.filled      (fill[g+1]),
			.ins         (ins)
		);
	end

	// Round-robin port allocator
	fafr_rr u_rr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step     (rr_step),
		.port_nxt (rr_port)
	);

	// Row moves unless the output register holds a result that m_tready has not taken
	assign adv       = !(out_vld_q && !m_tready);
	assign tail_done = probe[FLOWS].vld && adv;
	assign full      = (count_q == CW'(FLOWS));
	assign rr_step   = tail_done && !probe[FLOWS].hit;
	assign res_port  = probe[FLOWS].hit ? probe[FLOWS].dest : rr_port;

	assign ins.en    = rr_step && !full;
	assign ins.key   = probe[FLOWS].key;
	assign ins.dest  = rr_port;

	assign count_nxt = ins.en ? (count_q + CW'(1)) : count_q;
	assign total_ext = 32'(count_nxt);

	// One item in the row at a time; the flow count follows inserts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
			end else if (tail_done) begin
				busy_q <= 1'b0;
			end
			count_q <= count_nxt;
		end
	end

	// Entry only when no item is in flight and the row can advance
	assign s_tready = !busy_q && adv;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tail_done) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_done) begin
			out_data_q <= {1'b0, total_ext[8:0], rr_step && full, !probe[FLOWS].hit,
				res_port};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Fill flag of the last slot agrees with a full flow count
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		fill[FLOWS] == full)
		else $error("last slot fill flag disagrees with flow count");

	// A probe only reaches the end of the row while an item is in flight
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		probe[FLOWS].vld |-> busy_q)
		else $error("probe at end of row with no item in flight");

	// An insert bumps the flow count by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins.en |=> (count_q == $past(count_q) + CW'(1)))
		else $error("flow count did not follow insert");

	// A full-table result is always a new flow
	a_full_new: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[5]) |-> m_tdata[4])
		else $error("table_full set on a known flow");

endmodule
